/* hw/rtl/ofmg_pkg.sv */
package ofmg_pkg;

  // status byte that marks a valid motion report
  localparam logic [7:0]  VALID_STATUS = 8'hB0;
  // axis magnitudes above this are outliers
  localparam logic signed [15:0] AXIS_MAX = 16'sd99;
  localparam logic [7:0]  QUALITY_MIN  = 8'd50;
  localparam logic [15:0] SHUTTER_MAX  = 16'd2000;
  // adaptive deviation: ((shutter * slope) >> 10) + offset, floored
  localparam logic [9:0]  STD_SLOPE    = 10'd837;
  localparam logic [15:0] STD_OFFSET   = 16'd444;
  localparam logic [15:0] STD_FLOOR    = 16'd102;
  localparam logic [15:0] STD_RESET    = 16'd2048;
  localparam logic [31:0] DT_MIN       = 32'd1000;
  localparam logic [31:0] DT_MAX       = 32'd50000;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOW_DISABLED = 2'd0,
    CFG_ADAPTIVE_STD  = 2'd1,
    CFG_FIXED_STD     = 2'd2
  } ofmg_cfg_idx_e;

  typedef enum logic [2:0] {
    VERDICT_SENT        = 3'd0,
    VERDICT_READ_FAILED = 3'd1,
    VERDICT_OUTLIER     = 3'd2,
    VERDICT_POOR        = 3'd3,
    VERDICT_NOT_SENT    = 3'd4,
    VERDICT_DT_LONG     = 3'd5
  } ofmg_verdict_e;

  typedef struct packed {
    logic        flow_disabled;
    logic        adaptive_std;
    logic [15:0] fixed_std;
  } ofmg_cfg_t;

  typedef struct packed {
    logic        read_ok;
    logic [7:0]  motion_status;
    logic [15:0] delta_x;
    logic [15:0] delta_y;
    logic [7:0]  surface_quality;
    logic [15:0] shutter_time;
    logic [31:0] time_us;
  } ofmg_item_t;

  typedef struct packed {
    ofmg_verdict_e verdict;
    logic [7:0]    flow_x;
    logic [7:0]    flow_y;
    logic [15:0]   std_dev;
    logic [15:0]   dt_us;
    logic [7:0]    outlier_total;
  } ofmg_res_t;

endpackage

/* hw/rtl/ofmg_eval.sv */
module ofmg_eval import ofmg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ofmg_cfg_t  cfg_i,
  input  ofmg_item_t item_i,
  input  logic       step_i,
  output ofmg_res_t  res_o
);

  logic        held_valid_q;
  logic [15:0] held_dx_q, held_dy_q, held_shutter_q;
  logic [7:0]  held_quality_q;
  logic [31:0] last_time_q, last_time_d;
  logic [7:0]  outlier_cnt_q, outlier_cnt_d;
  logic [15:0] cur_std_q, cur_std_d;

  logic        missed, use_held, capture;
  logic [7:0]  status, quality;
  logic [15:0] dx, dy, shutter;
  logic        is_outlier, is_poor, passed, send;
  logic [25:0] std_prod;
  logic [16:0] std_sum;
  logic [15:0] std_adapt, std_new;
  logic [31:0] dt;
  logic [15:0] dt_clamped;
  ofmg_verdict_e verdict;

  // failed read falls back to the held report
  assign use_held = !item_i.read_ok;
  assign missed   = use_held && !held_valid_q;
  assign capture  = item_i.read_ok && (item_i.motion_status == VALID_STATUS);

  assign status  = use_held ? VALID_STATUS   : item_i.motion_status;
  assign dx      = use_held ? held_dx_q      : item_i.delta_x;
  assign dy      = use_held ? held_dy_q      : item_i.delta_y;
  assign quality = use_held ? held_quality_q : item_i.surface_quality;
  assign shutter = use_held ? held_shutter_q : item_i.shutter_time;

  assign is_outlier = ($signed(dx) > AXIS_MAX) || ($signed(dx) < -AXIS_MAX)
                   || ($signed(dy) > AXIS_MAX) || ($signed(dy) < -AXIS_MAX);
  assign is_poor    = (quality < QUALITY_MIN) || (shutter >= SHUTTER_MAX);
  assign passed     = !missed && !is_outlier && !is_poor;
  assign send       = passed && !cfg_i.flow_disabled && (status == VALID_STATUS);

  assign std_prod  = 26'(shutter) * 26'(STD_SLOPE);
  assign std_sum   = 17'(std_prod[25:10]) + 17'(STD_OFFSET);
  assign std_adapt = (std_sum[15:0] < STD_FLOOR) ? STD_FLOOR : std_sum[15:0];
  assign std_new   = cfg_i.adaptive_std ? std_adapt : cfg_i.fixed_std;

  assign dt         = item_i.time_us - last_time_q;
  assign dt_clamped = (dt < DT_MIN) ? DT_MIN[15:0] : dt[15:0];

  always_comb begin
    priority if (missed)                verdict = VERDICT_READ_FAILED;
    else if (is_outlier)                verdict = VERDICT_OUTLIER;
    else if (is_poor)                   verdict = VERDICT_POOR;
    else if (!send)                     verdict = VERDICT_NOT_SENT;
    else if (dt > DT_MAX)               verdict = VERDICT_DT_LONG;
    else                                verdict = VERDICT_SENT;
  end

  assign outlier_cnt_d = (!missed && (is_outlier || is_poor)) ? outlier_cnt_q + 8'd1
                                                               : outlier_cnt_q;
  assign cur_std_d     = passed ? std_new : cur_std_q;
  assign last_time_d   = send ? item_i.time_us : last_time_q;

  always_comb begin
    res_o.verdict       = verdict;
    res_o.std_dev       = cur_std_d;
    res_o.outlier_total = outlier_cnt_d;
    if (verdict == VERDICT_SENT) begin
      res_o.flow_x = 8'(16'd0 - dy);
      res_o.flow_y = 8'(16'd0 - dx);
      res_o.dt_us  = dt_clamped;
    end else begin
      res_o.flow_x = '0;
      res_o.flow_y = '0;
      res_o.dt_us  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q   <= 1'b0;
      held_dx_q      <= '0;
      held_dy_q      <= '0;
      held_quality_q <= '0;
      held_shutter_q <= '0;
      last_time_q    <= '0;
      outlier_cnt_q  <= '0;
      cur_std_q      <= STD_RESET;
    end else if (step_i) begin
      if (capture) begin
        held_valid_q   <= 1'b1;
        held_dx_q      <= item_i.delta_x;
        held_dy_q      <= item_i.delta_y;
        held_quality_q <= item_i.surface_quality;
        held_shutter_q <= item_i.shutter_time;
      end
      last_time_q   <= last_time_d;
      outlier_cnt_q <= outlier_cnt_d;
      cur_std_q     <= cur_std_d;
    end
  end

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (verdict == VERDICT_OUTLIER || verdict == VERDICT_POOR)
    |=> outlier_cnt_q == 8'($past(outlier_cnt_q) + 8'd1))
    else $error("outlier count did not advance on a rejected report");

  a_time_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (verdict != VERDICT_SENT) && (verdict != VERDICT_DT_LONG)
    |=> $stable(last_time_q))
    else $error("last send time moved without a send attempt");

  // a failed read with nothing held leaves the gate state alone
  a_missed_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && missed
    |=> $stable(outlier_cnt_q) && $stable(cur_std_q) && $stable(held_valid_q))
    else $error("gate state moved on a failed read with nothing held");

endmodule

/* hw/rtl/optical_flow_measurement_gate_core.sv */
// path: an accepted word is held in the input register, evaluated, and its result is
//   captured in the result register, where it stays until out_ready_i takes it
// throughput: one word per cycle; the input register and result register
//   form a two-stage pipeline that only stalls when out_ready_i is low
// reset (rst_ni low, async): pipeline empty, no held report, outlier count 0,
//   deviation 2048, last send time 0, flow enabled, adaptive deviation on
module optical_flow_measurement_gate_core import ofmg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  read_ok_i,
  input  logic [7:0]            motion_status_i,
  input  logic signed [15:0]    delta_x_i,
  input  logic signed [15:0]    delta_y_i,
  input  logic [7:0]            surface_quality_i,
  input  logic [15:0]           shutter_time_i,
  input  logic [31:0]           time_us_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            verdict_o,
  output logic signed [7:0]     flow_x_o,
  output logic signed [7:0]     flow_y_o,
  output logic [15:0]           std_dev_o,
  output logic [15:0]           dt_us_o,
  output logic [7:0]            outlier_total_o
);

  // configuration registers
  ofmg_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flow_disabled <= 1'b0;
      cfg_q.adaptive_std  <= 1'b1;
      cfg_q.fixed_std     <= STD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLOW_DISABLED: cfg_q.flow_disabled <= cfg_wdata_i[0];
        CFG_ADAPTIVE_STD:  cfg_q.adaptive_std  <= cfg_wdata_i[0];
        CFG_FIXED_STD:     cfg_q.fixed_std     <= cfg_wdata_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // stage 1: input register
  logic       s1_valid_q;
  ofmg_item_t s1_item_q;
  logic       s1_adv;   // stage 1 word moves into the result register
  logic       in_fire;

  // stage 2: result register
  logic      out_valid_q;
  ofmg_res_t out_res_q;
  ofmg_res_t eval_res;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.read_ok         <= read_ok_i;
      s1_item_q.motion_status   <= motion_status_i;
      s1_item_q.delta_x         <= delta_x_i;
      s1_item_q.delta_y         <= delta_y_i;
      s1_item_q.surface_quality <= surface_quality_i;
      s1_item_q.shutter_time    <= shutter_time_i;
      s1_item_q.time_us         <= time_us_i;
    end
  end

  // gating decision and report state; state commits as the word retires
  ofmg_eval u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .item_i (s1_item_q),
    .step_i (s1_adv),
    .res_o  (eval_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= eval_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign verdict_o       = out_res_q.verdict;
  assign flow_x_o        = out_res_q.flow_x;
  assign flow_y_o        = out_res_q.flow_y;
  assign std_dev_o       = out_res_q.std_dev;
  assign dt_us_o         = out_res_q.dt_us;
  assign outlier_total_o = out_res_q.outlier_total;

  // a sent word always carries a clamped dt
  a_sent_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.verdict == VERDICT_SENT)
    |-> (out_res_q.dt_us >= DT_MIN[15:0]) && (out_res_q.dt_us <= DT_MAX[15:0]))
    else $error("sent word with dt outside the clamp range");

  // rejected words carry no flow and no dt
  a_unsent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.verdict != VERDICT_SENT)
    |-> (out_res_q.flow_x == 8'd0) && (out_res_q.flow_y == 8'd0)
        && (out_res_q.dt_us == 16'd0))
    else $error("unsent word carries flow or dt");

  // a stalled result is never overwritten by stage 1
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !s1_adv)
    else $error("stage 1 advanced into a stalled result register");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ofmg_pkg::*;

  // behavior constants for the predictor
  localparam logic [7:0]  GOOD_STATUS   = 8'hB0;
  localparam int          AXIS_LIMIT    = 100;
  localparam logic [7:0]  QUALITY_FLOOR = 8'd50;
  localparam logic [15:0] SHUTTER_LIMIT = 16'd2000;
  localparam logic [31:0] DEV_SLOPE     = 32'd837;
  localparam logic [31:0] DEV_OFFSET    = 32'd444;
  localparam logic [31:0] DEV_FLOOR     = 32'd102;
  localparam logic [31:0] DT_FLOOR_US   = 32'd1000;
  localparam logic [31:0] DT_LIMIT_US   = 32'd50000;

  // only the input and result registers hold words, so this drain covers anything still in flight
  localparam int DRAIN_CYCLES = 4;
  localparam int TIMEOUT_NS   = 5_000_000;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // register write port
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // report channel
  logic               in_valid        = 1'b0;
  logic               in_ready;
  logic               read_ok         = 1'b0;
  logic [7:0]         motion_status   = '0;
  logic signed [15:0] delta_x         = '0;
  logic signed [15:0] delta_y         = '0;
  logic [7:0]         surface_quality = '0;
  logic [15:0]        shutter_time    = '0;
  logic [31:0]        time_us         = '0;

  // verdict channel
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         verdict;
  logic signed [7:0]  flow_x;
  logic signed [7:0]  flow_y;
  logic [15:0]        std_dev;
  logic [15:0]        dt_us;
  logic [7:0]         outlier_total;

  // idle control shared by both sides, percent chance to start a burst
  int unsigned idle_pct   = 0;
  bit          allow_idle = 1'b1;
  int unsigned stall_left = 0;

  // running sensor timestamp for random reports
  logic [31:0] now_us = '0;
  int unsigned settings_used = 0;

  // predicts the gate and checks every verdict word against it
  class flow_gate_checker;
    // register copies
    bit          flow_off;
    bit          adaptive_dev;
    logic [15:0] fixed_dev;
    // last good report and gate state
    bit          held_ok;
    logic [15:0] held_dx;
    logic [15:0] held_dy;
    logic [7:0]  held_quality;
    logic [15:0] held_shutter;
    logic [31:0] last_sent_us;
    logic [7:0]  rejects;
    logic [15:0] dev_now;

    ofmg_res_t   pending_verdicts[$];
    int unsigned mismatches;
    int unsigned reports_seen;
    int unsigned verdict_hits[6];

    function new();
      flow_off     = 1'b0;
      adaptive_dev = 1'b1;
      fixed_dev    = 16'd2048;
      held_ok      = 1'b0;
      held_dx      = '0;
      held_dy      = '0;
      held_quality = '0;
      held_shutter = '0;
      last_sent_us = '0;
      rejects      = '0;
      dev_now      = 16'd2048;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FLOW_DISABLED: flow_off = data[0];
        CFG_ADAPTIVE_STD:  adaptive_dev = data[0];
        CFG_FIXED_STD:     fixed_dev = data;
        default: ;
      endcase
    endfunction

    function ofmg_res_t gate_report(ofmg_item_t it);
      ofmg_res_t   r;
      logic [7:0]  status;
      logic [7:0]  quality;
      logic [15:0] dx;
      logic [15:0] dy;
      logic [15:0] shutter;
      int          fx;
      int          fy;
      logic [31:0] dt;
      logic [31:0] dev;
      r         = '0;
      r.verdict = VERDICT_SENT;
      status    = it.motion_status;
      quality   = it.surface_quality;
      dx        = it.delta_x;
      dy        = it.delta_y;
      shutter   = it.shutter_time;
      if (!it.read_ok && !held_ok) begin
        r.verdict = VERDICT_READ_FAILED;
      end else begin
        if (!it.read_ok) begin
          // replay the last good report
          status  = GOOD_STATUS;
          dx      = held_dx;
          dy      = held_dy;
          quality = held_quality;
          shutter = held_shutter;
        end else if (status == GOOD_STATUS) begin
          held_ok      = 1'b1;
          held_dx      = dx;
          held_dy      = dy;
          held_quality = quality;
          held_shutter = shutter;
        end
        // axes swap and flip
        fx = -int'($signed(dy));
        fy = -int'($signed(dx));
        if (fx >= AXIS_LIMIT || -fx >= AXIS_LIMIT || fy >= AXIS_LIMIT || -fy >= AXIS_LIMIT)
        begin
          rejects++;
          r.verdict = VERDICT_OUTLIER;
        end else if (quality < QUALITY_FLOOR || shutter >= SHUTTER_LIMIT) begin
          rejects++;
          r.verdict = VERDICT_POOR;
        end else begin
          if (adaptive_dev) begin
            dev = ((32'(shutter) * DEV_SLOPE) >> 10) + DEV_OFFSET;
            if (dev < DEV_FLOOR) dev = DEV_FLOOR;
            dev_now = dev[15:0];
          end else begin
            dev_now = fixed_dev;
          end
          if (flow_off || status != GOOD_STATUS) begin
            r.verdict = VERDICT_NOT_SENT;
          end else begin
            dt           = it.time_us - last_sent_us;
            last_sent_us = it.time_us;
            if (dt < DT_FLOOR_US) dt = DT_FLOOR_US;
            else if (dt > DT_LIMIT_US) r.verdict = VERDICT_DT_LONG;
            if (r.verdict == VERDICT_SENT) begin
              r.flow_x = fx[7:0];
              r.flow_y = fy[7:0];
              r.dt_us  = dt[15:0];
            end
          end
        end
      end
      r.std_dev       = dev_now;
      r.outlier_total = rejects;
      return r;
    endfunction

    function void note_report(ofmg_item_t it);
      reports_seen++;
      pending_verdicts.push_back(gate_report(it));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task check_result(ofmg_res_t got);
      ofmg_res_t want;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("verdict word with no report pending", got.verdict, '0);
        return;
      end
      want = pending_verdicts.pop_front();
      verdict_hits[want.verdict]++;
      if (got.verdict !== want.verdict) report_mismatch("verdict", got.verdict, want.verdict);
      if (got.flow_x !== want.flow_x) report_mismatch("flow_x", got.flow_x, want.flow_x);
      if (got.flow_y !== want.flow_y) report_mismatch("flow_y", got.flow_y, want.flow_y);
      if (got.std_dev !== want.std_dev) report_mismatch("std_dev", got.std_dev, want.std_dev);
      if (got.dt_us !== want.dt_us) report_mismatch("dt_us", got.dt_us, want.dt_us);
      if (got.outlier_total !== want.outlier_total)
        report_mismatch("outlier_total", got.outlier_total, want.outlier_total);
    endtask
  endclass

  flow_gate_checker sb = new();

  optical_flow_measurement_gate_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .read_ok_i         (read_ok),
    .motion_status_i   (motion_status),
    .delta_x_i         (delta_x),
    .delta_y_i         (delta_y),
    .surface_quality_i (surface_quality),
    .shutter_time_i    (shutter_time),
    .time_us_i         (time_us),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .verdict_o         (verdict),
    .flow_x_o          (flow_x),
    .flow_y_o          (flow_y),
    .std_dev_o         (std_dev),
    .dt_us_o           (dt_us),
    .outlier_total_o   (outlier_total)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // sample at the edge, before any of this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) sb.write_reg(cfg_idx, cfg_wdata);
      if (in_valid && in_ready)
        sb.note_report({read_ok, motion_status, delta_x, delta_y, surface_quality,
                        shutter_time, time_us});
      if (out_valid && out_ready)
        sb.check_result({verdict, flow_x, flow_y, std_dev, dt_us, outlier_total});
    end
  end

  // receiver stalls in bursts of random length
  always @(posedge clk_i) begin
    if (stall_left != 0) stall_left--;
    else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
      stall_left = $urandom_range(1, 7);
    out_ready <= (stall_left == 0);
  end

  // present one word and hold it until the block takes it
  task automatic send_report(ofmg_item_t it);
    in_valid        <= 1'b1;
    read_ok         <= it.read_ok;
    motion_status   <= it.motion_status;
    delta_x         <= it.delta_x;
    delta_y         <= it.delta_y;
    surface_quality <= it.surface_quality;
    shutter_time    <= it.shutter_time;
    time_us         <= it.time_us;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // all three registers, one per edge; spare data bits of the flags are junk
  task automatic apply_settings(bit off, bit adaptive, logic [15:0] fixed_val);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FLOW_DISABLED;
    cfg_wdata <= {15'($urandom), off};
    @(posedge clk_i);
    cfg_idx   <= CFG_ADAPTIVE_STD;
    cfg_wdata <= {15'($urandom), adaptive};
    @(posedge clk_i);
    cfg_idx   <= CFG_FIXED_STD;
    cfg_wdata <= fixed_val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // stop sending and let every verdict come back; the first edge lets the
  // sampler note a word taken at the edge the sender just returned from
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic ofmg_item_t motion_report(bit ok, logic [7:0] st, int dx, int dy,
                                               int q, int sh, logic [31:0] t);
    ofmg_item_t it;
    it.read_ok         = ok;
    it.motion_status   = st;
    it.delta_x         = 16'(dx);
    it.delta_y         = 16'(dy);
    it.surface_quality = 8'(q);
    it.shutter_time    = 16'(sh);
    it.time_us         = t;
    return it;
  endfunction

  // mostly in range, some right at the limit, some anything
  function automatic logic [15:0] random_axis();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return 16'($urandom_range(0, 198) - 99);
    if (pick < 85) return $urandom_range(0, 1) ? 16'($urandom_range(95, 105))
                                                : 16'(-int'($urandom_range(95, 105)));
    return 16'($urandom);
  endfunction

  // well-formed motion most of the time, with noise mixed in
  function automatic ofmg_item_t random_report();
    ofmg_item_t it;
    int pick;
    it.read_ok       = ($urandom_range(0, 99) < 90);
    it.motion_status = ($urandom_range(0, 99) < 80) ? GOOD_STATUS : 8'($urandom);
    it.delta_x       = random_axis();
    it.delta_y       = random_axis();
    it.surface_quality = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(50, 255))
                                                      : 8'($urandom_range(0, 60));
    pick = $urandom_range(0, 99);
    if (pick < 85) it.shutter_time = 16'($urandom_range(0, 1999));
    else if (pick < 95) it.shutter_time = 16'($urandom_range(1990, 2010));
    else it.shutter_time = 16'($urandom);
    // time steps: short, normal, around the 50 ms edge, or a jump anywhere
    pick = $urandom_range(0, 99);
    if (pick < 20) now_us += $urandom_range(0, 1500);
    else if (pick < 80) now_us += $urandom_range(1000, 30000);
    else if (pick < 90) now_us += $urandom_range(49990, 50010);
    else now_us = $urandom;
    it.time_us = now_us;
    return it;
  endfunction

  task automatic run_reports(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      // new idle mix every hundred words, including quiet stretches
      if (i % 100 == 0) begin
        if (!allow_idle) idle_pct = 0;
        else case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      send_report(random_report());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words under reset settings, receiver stalling now and then
    idle_pct = 25;
    // failed read before anything was held
    send_report(motion_report(0, 8'h00, 0, 0, 0, 0, 32'd100));
    // first good report, short dt raised to the floor, zero shutter
    send_report(motion_report(1, GOOD_STATUS, 5, -7, 100, 0, 32'd500));
    // failed read replays the held report, its own fields ignored
    send_report(motion_report(0, 8'hFF, 32767, -32768, 0, 65535, 32'd2000));
    // bad status: deviation still moves, nothing sent
    send_report(motion_report(1, 8'h00, 3, 3, 200, 1000, 32'd2500));
    send_report(motion_report(1, 8'hFF, 3, 3, 200, 1500, 32'd2600));
    // largest axes that pass, lowest quality and highest shutter that pass
    send_report(motion_report(1, GOOD_STATUS, 99, -99, 50, 1999, 32'd3499));
    send_report(motion_report(1, GOOD_STATUS, -99, 99, 255, 1000, 32'd4498));
    // outliers, one of them replayed by a failed read
    send_report(motion_report(1, GOOD_STATUS, 100, 0, 100, 100, 32'd5000));
    send_report(motion_report(0, 8'h00, 0, 0, 100, 100, 32'd5100));
    send_report(motion_report(1, GOOD_STATUS, 0, -100, 100, 100, 32'd5200));
    send_report(motion_report(1, GOOD_STATUS, -32768, 0, 100, 100, 32'd5300));
    send_report(motion_report(1, GOOD_STATUS, 0, 32767, 100, 100, 32'd5400));
    send_report(motion_report(1, GOOD_STATUS, 32767, -32768, 100, 100, 32'd5500));
    // poor surface or long shutter
    send_report(motion_report(1, GOOD_STATUS, 1, 1, 49, 100, 32'd5600));
    send_report(motion_report(1, GOOD_STATUS, 1, 1, 0, 100, 32'd5700));
    send_report(motion_report(1, GOOD_STATUS, 1, 1, 100, 2000, 32'd5800));
    send_report(motion_report(1, GOOD_STATUS, 1, 1, 100, 65535, 32'd5900));
    // dt exactly at the limit, just over, then back to the floor
    send_report(motion_report(1, GOOD_STATUS, 0, 0, 80, 300, 32'd54498));
    send_report(motion_report(1, GOOD_STATUS, 2, 2, 80, 300, 32'd104499));
    send_report(motion_report(1, GOOD_STATUS, -1, 1, 80, 300, 32'd105499));
    // time steps backwards, then to the top, then wraps forward
    send_report(motion_report(1, GOOD_STATUS, 4, -4, 80, 300, 32'd100));
    send_report(motion_report(1, GOOD_STATUS, 4, -4, 80, 300, 32'hFFFF_FFFF));
    send_report(motion_report(1, GOOD_STATUS, -4, 4, 80, 300, 32'd2000));
    send_report(motion_report(1, GOOD_STATUS, 0, 0, 255, 1999, 32'd0));
    settle();
    now_us = 32'd10_000;

    // adaptive deviation, flow on; sender holds off once until all is back
    apply_settings(1'b0, 1'b1, 16'($urandom));
    run_reports(300);
    settle();
    run_reports(300);
    settle();

    // flow off, fixed deviation of zero
    apply_settings(1'b1, 1'b0, 16'h0000);
    run_reports(350);
    settle();

    // flow on, fixed deviation at the top
    apply_settings(1'b0, 1'b0, 16'hFFFF);
    run_reports(350);
    settle();

    // back to adaptive, last stretch with no idling on either side
    apply_settings(1'b0, 1'b1, 16'd2048);
    run_reports(500);
    allow_idle = 1'b0;
    run_reports(200);
    settle();

    $display("covered %0d reports under %0d register settings", sb.reports_seen,
             settings_used + 1);
    $display("verdicts: sent %0d, read failed %0d, outlier %0d, poor %0d, held back %0d, %s%0d",
             sb.verdict_hits[VERDICT_SENT], sb.verdict_hits[VERDICT_READ_FAILED],
             sb.verdict_hits[VERDICT_OUTLIER], sb.verdict_hits[VERDICT_POOR],
             sb.verdict_hits[VERDICT_NOT_SENT], "dt too long ",
             sb.verdict_hits[VERDICT_DT_LONG]);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/ofmg_pkg.sv
hw/rtl/ofmg_eval.sv
hw/rtl/optical_flow_measurement_gate_core.sv
tb/testbench.sv
